### rtl/skt_pkg.sv
`timescale 1ns / 1ps

package skt_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 64;

	localparam int CMD_W     = 2;
	localparam int KEY_W     = 64;
	localparam int PAYLOAD_W = 32;
	localparam int POS_W     = 7;
	localparam int COUNT_W   = 7;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_APPLY
	} state_t;

	// compare outcome of one cell against the broadcast key
	typedef struct packed {
		logic lt;
		logic le;
		logic eq;
	} cell_flags_t;

endpackage

### rtl/sorted_key_table.sv
`timescale 1ns / 1ps

// Sorted key table: up to CAPACITY entries of (key, payload) kept in ascending unsigned
// key order in a row of cells, one entry per cell. Each word is captured, then every cell
// compares its key with the broadcast key, and then the compare flags are encoded into
// the position and every cell above the insertion point takes its lower neighbor's
// entry. A new word is taken once the previous one has moved into the output register,
// so the block does not take a new word while it still works on the last one. Lookups
// return the lowest matching index; inserts go after equal keys and are refused with
// status set when the table is full. Clear only zeros the entry count and reset also
// zeros it; cell keys and payloads are not cleared.
module sorted_key_table #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
	parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [skt_pkg::CMD_W-1:0]     command,
	input  logic [skt_pkg::KEY_W-1:0]     key,
	input  logic [skt_pkg::PAYLOAD_W-1:0] payload,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [skt_pkg::POS_W-1:0]     position,
	output logic                          status,
	output logic [skt_pkg::PAYLOAD_W-1:0] payload_out,
	output logic [skt_pkg::COUNT_W-1:0]   entry_count
);
	import skt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	state_t state_q, state_d;

	cmd_t                 cmd_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [PAYLOAD_W-1:0] payload_q;
	logic [CW-1:0]        count_q;

	logic cmp_en, apply, out_free, full, is_ins, ins_en;

	logic [KEY_BITS-1:0]                  cell_key [CAPACITY];
	logic [CAPACITY-1:0][PAYLOAD_W-1:0]   cell_pl;
	cell_flags_t                          cell_flags [CAPACITY];
	logic [CAPACITY-1:0]                  occ, lt_v, le_v, eq_v, below;

	logic [CW-1:0]        enc_pos;
	logic                 enc_hit;
	logic [PAYLOAD_W-1:0] enc_payload;

	logic                 out_valid_q, found_q, status_q;
	logic [POS_W-1:0]     position_q;
	logic [PAYLOAD_W-1:0] payload_out_q;
	logic [COUNT_W-1:0]   entry_count_q;
	logic [CW-1:0]        count_d;

	// control sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_CMP;
			ST_CMP:   state_d = ST_APPLY;
			ST_APPLY: if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmp_en   = (state_q == ST_CMP);
		apply    = (state_q == ST_APPLY) && out_free;
	end

	assign out_free = !out_valid_q || out_ready;
	assign full     = (count_q == CW'(CAPACITY));
	assign is_ins   = (cmd_q == CMD_INSERT);
	assign ins_en   = apply && is_ins && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_NOP;
		end else begin
			state_q <= state_d;
			if (in_valid && in_ready) begin
				cmd_q <= cmd_t'(command);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			key_q     <= key[KEY_BITS-1:0];
			payload_q <= payload;
		end
	end

	// row of cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic                 prev_le;
		logic [KEY_BITS-1:0]  prev_key;
		logic [PAYLOAD_W-1:0] prev_payload;

		if (g == 0) begin : g_head
			assign prev_le      = 1'b1;
			assign prev_key     = key_q;
			assign prev_payload = payload_q;
		end else begin : g_body
			assign prev_le      = cell_flags[g-1].le;
			assign prev_key     = cell_key[g-1];
			assign prev_payload = cell_pl[g-1];
		end

		assign occ[g]  = (count_q > CW'(g));
		assign lt_v[g] = cell_flags[g].lt;
		assign le_v[g] = cell_flags[g].le;
		assign eq_v[g] = cell_flags[g].eq;

		skt_cell #(
			.KEY_BITS(KEY_BITS)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmp_en       (cmp_en),
			.ins_en       (ins_en),
			.occ          (occ[g]),
			.key_in       (key_q),
			.payload_in   (payload_q),
			.prev_le      (prev_le),
			.prev_key     (prev_key),
			.prev_payload (prev_payload),
			.key_out      (cell_key[g]),
			.payload_out  (cell_pl[g]),
			.flags        (cell_flags[g])
		);
	end

	// lookup wants the lower bound, insert the upper bound
	assign below = is_ins ? le_v : lt_v;

	skt_enc #(
		.CAPACITY(CAPACITY)
	) u_enc (
		.below       (below),
		.eq          (eq_v),
		.payloads    (cell_pl),
		.pos         (enc_pos),
		.hit         (enc_hit),
		.hit_payload (enc_payload)
	);

	always_comb begin
		unique case (cmd_q)
			CMD_INSERT: count_d = full ? count_q : count_q + CW'(1);
			CMD_CLEAR:  count_d = '0;
			default:    count_d = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (apply) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			entry_count_q <= COUNT_W'(count_d);
			unique case (cmd_q)
				CMD_LOOKUP: begin
					found_q       <= enc_hit;
					status_q      <= 1'b0;
					position_q    <= POS_W'(enc_pos);
					payload_out_q <= enc_hit ? enc_payload : '0;
				end
				CMD_INSERT: begin
					found_q       <= 1'b0;
					status_q      <= full;
					position_q    <= full ? '0 : POS_W'(enc_pos);
					payload_out_q <= '0;
				end
				default: begin
					found_q       <= 1'b0;
					status_q      <= 1'b0;
					position_q    <= '0;
					payload_out_q <= '0;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign position    = position_q;
	assign status      = status_q;
	assign payload_out = payload_out_q;
	assign entry_count = entry_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_CMP) ##1 (state_q == ST_APPLY))
		else $error("accepted word skipped compare or apply");

	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		ins_en |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the table by one");

	a_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(apply && is_ins && full) |=> ($stable(count_q) && status_q && !found_q))
		else $error("refused insert changed the table");

	a_found_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && found_q) |-> (!status_q && position_q < POS_W'(entry_count_q)))
		else $error("hit reported outside the held entries");

endmodule

### rtl/skt_cell.sv
`timescale 1ns / 1ps

module skt_cell #(
	parameter int KEY_BITS = skt_pkg::KEY_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmp_en,
	input  logic                          ins_en,
	input  logic                          occ,
	input  logic [KEY_BITS-1:0]           key_in,
	input  logic [skt_pkg::PAYLOAD_W-1:0] payload_in,
	input  logic                          prev_le,
	input  logic [KEY_BITS-1:0]           prev_key,
	input  logic [skt_pkg::PAYLOAD_W-1:0] prev_payload,
	output logic [KEY_BITS-1:0]           key_out,
	output logic [skt_pkg::PAYLOAD_W-1:0] payload_out,
	output skt_pkg::cell_flags_t          flags
);
	import skt_pkg::*;

	logic [KEY_BITS-1:0]  key_q;
	logic [PAYLOAD_W-1:0] payload_q;
	cell_flags_t          flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (cmp_en) begin
			flags_q.lt <= occ && (key_q < key_in);
			flags_q.le <= occ && (key_q <= key_in);
			flags_q.eq <= occ && (key_q == key_in);
		end
	end

	// cells above the insertion point move up one; the boundary cell takes the new entry
	always_ff @(posedge clk) begin
		if (ins_en && !flags_q.le) begin
			if (prev_le) begin
				key_q     <= key_in;
				payload_q <= payload_in;
			end else begin
				key_q     <= prev_key;
				payload_q <= prev_payload;
			end
		end
	end

	assign key_out     = key_q;
	assign payload_out = payload_q;
	assign flags       = flags_q;

endmodule

### rtl/skt_enc.sv
`timescale 1ns / 1ps

module skt_enc #(
	parameter int CAPACITY = skt_pkg::CAPACITY_DEF,
	localparam int CW      = $clog2(CAPACITY + 1)
) (
	input  logic [CAPACITY-1:0]                         below,
	input  logic [CAPACITY-1:0]                         eq,
	input  logic [CAPACITY-1:0][skt_pkg::PAYLOAD_W-1:0] payloads,
	output logic [CW-1:0]                               pos,
	output logic                                        hit,
	output logic [skt_pkg::PAYLOAD_W-1:0]               hit_payload
);
	import skt_pkg::*;

	logic [CAPACITY:0] ext;
	logic [CAPACITY:0] edge_v;

	// below is a prefix mask, so exactly one edge bit marks its end
	assign ext = {1'b0, below};

	always_comb begin
		edge_v[0] = !ext[0];
		for (int i = 1; i <= CAPACITY; i++) begin
			edge_v[i] = !ext[i] && ext[i-1];
		end
	end

	always_comb begin
		pos         = '0;
		hit         = 1'b0;
		hit_payload = '0;
		for (int i = 0; i <= CAPACITY; i++) begin
			pos = pos | (edge_v[i] ? CW'(i) : '0);
		end
		for (int i = 0; i < CAPACITY; i++) begin
			hit         = hit | (edge_v[i] & eq[i]);
			hit_payload = hit_payload | (edge_v[i] ? payloads[i] : '0);
		end
	end

endmodule

### dv/sorted_key_table_tb.sv
`timescale 1ns / 1ps

module sorted_key_table_tb;
	import skt_pkg::*;

	localparam int CAPACITY    = CAPACITY_DEF;
	localparam int RANDOM_WORDS = 1300;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 12;

	typedef struct packed {
		logic                 found;
		logic [POS_W-1:0]     position;
		logic                 status;
		logic [PAYLOAD_W-1:0] payload_out;
		logic [COUNT_W-1:0]   entry_count;
	} lookup_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [CMD_W-1:0]     command = CMD_NOP;
	logic [KEY_W-1:0]     key = '0;
	logic [PAYLOAD_W-1:0] payload = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic                 found;
	logic [POS_W-1:0]     position;
	logic                 status;
	logic [PAYLOAD_W-1:0] payload_out;
	logic [COUNT_W-1:0]   entry_count;

	// shadow copy of the sorted entries
	logic [KEY_W-1:0]     shadow_keys [CAPACITY];
	logic [PAYLOAD_W-1:0] shadow_handles [CAPACITY];
	int                   shadow_count = 0;

	lookup_result_t pending_results [$];
	int             error_count = 0;
	int             cycle_count = 0;
	int             burst_left = 0;
	int             stall_tick = 0;
	logic [15:0]    stall_pattern = 16'hFFFF;

	sorted_key_table dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.key         (key),
		.payload     (payload),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.position    (position),
		.status      (status),
		.payload_out (payload_out),
		.entry_count (entry_count)
	);

	always #6 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		error_count++;
	endtask

	// runs one word through the shadow table and returns what the block should answer
	function automatic lookup_result_t apply_word(input cmd_t cmd, input logic [KEY_W-1:0] k,
			input logic [PAYLOAD_W-1:0] pl);
		lookup_result_t res;
		int             slot;
		res = '0;
		slot = 0;
		case (cmd)
			CMD_LOOKUP: begin
				while (slot < shadow_count && shadow_keys[slot] < k)
					slot++;
				res.position = slot[POS_W-1:0];
				if (slot < shadow_count && shadow_keys[slot] == k) begin
					res.found = 1'b1;
					res.payload_out = shadow_handles[slot];
				end
			end
			CMD_INSERT: begin
				if (shadow_count >= CAPACITY) begin
					res.status = 1'b1;
				end else begin
					// new entry lands after every equal key
					while (slot < shadow_count && shadow_keys[slot] <= k)
						slot++;
					for (int i = shadow_count; i > slot; i--) begin
						shadow_keys[i] = shadow_keys[i-1];
						shadow_handles[i] = shadow_handles[i-1];
					end
					shadow_keys[slot] = k;
					shadow_handles[slot] = pl;
					shadow_count++;
					res.position = slot[POS_W-1:0];
				end
			end
			CMD_CLEAR: shadow_count = 0;
			default: ;
		endcase
		res.entry_count = shadow_count[COUNT_W-1:0];
		return res;
	endfunction

	task automatic send_word(input cmd_t cmd, input logic [KEY_W-1:0] k,
			input logic [PAYLOAD_W-1:0] pl);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		command  <= cmd;
		key      <= k;
		payload  <= pl;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(apply_word(cmd, k, pl));
	endtask

	function automatic logic [KEY_W-1:0] pick_key(input int mode);
		logic [KEY_W-1:0] k;
		int               len;
		k = '0;
		case (mode)
			0: k = {$urandom, $urandom};
			1: k = KEY_W'($urandom_range(0, 15));
			default: begin
				// short lower-case name, first char in the top byte, zero padded
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					k[KEY_W-1-8*i -: 8] = 8'($urandom_range(8'h61, 8'h7a));
			end
		endcase
		return k;
	endfunction

	task automatic test_empty_and_extremes();
		send_word(CMD_LOOKUP, '0, '1);
		send_word(CMD_LOOKUP, '1, '0);
		send_word(CMD_INSERT, '1, '1);
		send_word(CMD_INSERT, '0, '0);
		send_word(CMD_INSERT, 64'h6162_6300_0000_0000, 32'h1234_5678);
		send_word(CMD_LOOKUP, '1, '0);
		send_word(CMD_LOOKUP, '0, '1);
		send_word(CMD_LOOKUP, 64'h6162_0000_0000_0000, '0);
		send_word(CMD_LOOKUP, 64'h6162_6300_0000_0000, '0);
		send_word(CMD_NOP, {$urandom, $urandom}, $urandom);
		send_word(CMD_CLEAR, '1, '1);
		send_word(CMD_LOOKUP, '1, '0);
	endtask

	task automatic test_duplicates();
		send_word(CMD_INSERT, 64'h6b65_7900_0000_0000, 32'h0000_0001);
		send_word(CMD_INSERT, 64'h6b65_7900_0000_0000, 32'h0000_0002);
		send_word(CMD_INSERT, 64'h6a00_0000_0000_0000, 32'hAAAA_5555);
		send_word(CMD_INSERT, 64'h6b65_7900_0000_0000, 32'h0000_0003);
		send_word(CMD_INSERT, 64'h6b65_7a00_0000_0000, 32'h5555_AAAA);
		send_word(CMD_LOOKUP, 64'h6b65_7900_0000_0000, '0);
		send_word(CMD_LOOKUP, 64'h6b65_7800_0000_0000, '0);
		send_word(CMD_LOOKUP, 64'h6b65_7a00_0000_0000, '0);
		send_word(CMD_CLEAR, '0, '0);
	endtask

	task automatic test_full_table();
		repeat (CAPACITY)
			send_word(CMD_INSERT, pick_key($urandom_range(0, 2)), $urandom);
		send_word(CMD_INSERT, '0, '1);
		send_word(CMD_INSERT, '1, '1);
		send_word(CMD_LOOKUP, '1, '0);
		send_word(CMD_LOOKUP, shadow_keys[CAPACITY-1], '0);
		send_word(CMD_NOP, '1, '1);
		send_word(CMD_CLEAR, '1, '0);
	endtask

	task automatic test_random_mix();
		int               sent;
		int               span;
		int               insert_share;
		int               mode;
		int               roll;
		cmd_t             cmd;
		logic [KEY_W-1:0] k;
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			span = $urandom_range(20, 240);
			if (span > RANDOM_WORDS - sent)
				span = RANDOM_WORDS - sent;
			insert_share = $urandom_range(60, 170);
			mode = $urandom_range(0, 2);
			repeat (span) begin
				roll = $urandom_range(0, 199);
				if (roll < insert_share)
					cmd = CMD_INSERT;
				else if (roll < 194)
					cmd = CMD_LOOKUP;
				else if (roll < 199)
					cmd = CMD_NOP;
				else
					cmd = CMD_CLEAR;
				k = pick_key(mode);
				// most lookups aim at a held key or one of its neighbors
				if (cmd == CMD_LOOKUP && shadow_count > 0 && $urandom_range(0, 9) < 7) begin
					k = shadow_keys[$urandom_range(0, shadow_count - 1)];
					case ($urandom_range(0, 5))
						0: k = k + 1'b1;
						1: k = k - 1'b1;
						default: ;
					endcase
				end
				send_word(cmd, k, $urandom);
				sent++;
			end
			if ($urandom_range(0, 2) != 0) begin
				send_word(CMD_CLEAR, pick_key(0), $urandom);
				sent++;
			end
		end
	endtask

	// receiver stall pattern, reshuffled at random
	always @(posedge clk) begin
		if (stall_tick % 48 == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pattern = 16'hFFFF;
				1: stall_pattern = 16'($urandom);
				2: stall_pattern = 16'($urandom | $urandom);
				default: stall_pattern = 16'($urandom & $urandom);
			endcase
		end
		out_ready <= stall_pattern[stall_tick % 16];
		stall_tick++;
	end

	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result word with nothing pending");
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found)
					report_mismatch($sformatf("found got %0b exp %0b", found, want.found));
				if (position !== want.position)
					report_mismatch($sformatf("position got %0d exp %0d",
						position, want.position));
				if (status !== want.status)
					report_mismatch($sformatf("status got %0b exp %0b", status, want.status));
				if (payload_out !== want.payload_out)
					report_mismatch($sformatf("payload_out got %0h exp %0h",
						payload_out, want.payload_out));
				if (entry_count !== want.entry_count)
					report_mismatch($sformatf("entry_count got %0d exp %0d",
						entry_count, want.entry_count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sorted_key_table verification failed");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_extremes();
		test_duplicates();
		test_full_table();
		test_random_mix();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("sorted_key_table verification clean");
		else
			$display("sorted_key_table verification failed");
		$finish;
	end

endmodule
